FILE: src/mbc_pkg.sv
// Package for the Magma block cipher: function codes, key store sizes,
// the eight S-box tables and the round function.
// No dependencies; used by the top level.
package mbc_pkg;

  // Function codes carried by a request item.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ENC  = 2'd1;
  localparam logic [1:0] FUNC_DEC  = 2'd2;

  // Key store geometry and round count.
  localparam int         KEY_COUNT = 32;
  localparam int         KEY_AW    = $clog2(KEY_COUNT);
  localparam logic [KEY_AW-1:0] KEY_LAST = KEY_AW'(KEY_COUNT - 1);

  // Rotation applied after substitution.
  localparam int ROT_LEFT = 11;

  // Substitution tables: row n serves nibble n, counted from the least significant.
  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // One Feistel round function: key addition, substitution, rotation.
  function automatic logic [31:0] round_f(input logic [31:0] half, input logic [31:0] key);
    logic [31:0] sum;
    logic [31:0] sub;
    sum = half + key;
    for (int n = 0; n < 8; n++) begin
      sub[n*4 +: 4] = SBOX[n][sum[n*4 +: 4]];
    end
    return {sub[31-ROT_LEFT:0], sub[31:32-ROT_LEFT]};
  endfunction

endpackage

FILE: src/mbc_if.sv
// Handshake interfaces for the Magma block cipher: request and result channels.
// Depends on nothing but the payload widths fixed here.
interface mbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [4:0]  key_index;
  logic [31:0] key_word;
  logic [63:0] data_block;

  modport source (output valid, func, key_index, key_word, data_block, input ready);
  modport sink   (input valid, func, key_index, key_word, data_block, output ready);
endinterface

interface mbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_block;

  modport source (output valid, result_block, input ready);
  modport sink   (input valid, result_block, output ready);
endinterface

FILE: src/magma_block_cipher.sv
// Magma 64-bit Feistel block cipher with a 32-entry round key store.
// Depends on mbc_pkg and the interfaces in mbc_if.sv.
//
//   Channel  Role  Payload
//   req      sink  func, key_index, key_word, data_block
//   rsp      src   result_block
//
// A load item writes the key store in its accept cycle. An encrypt or decrypt
// item fetches its first key in the accept cycle, then runs one round per cycle
// through the single-port key memory. Ready stays low until the result is
// registered, so a new item is accepted only after the previous one finishes.
// The result sits in an output register; a full, untaken result stalls the last round.
// Reset is synchronous and clears control state only; keys are undefined until loaded.
module magma_block_cipher (
  input logic       clk,
  input logic       rst,
  mbc_req_if.sink   req,
  mbc_rsp_if.source rsp
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                    state;
  logic [mbc_pkg::KEY_AW-1:0] rnd;
  logic                      dir;
  logic [31:0]               hi;
  logic [31:0]               lo;
  logic [31:0]               key_q;
  logic                      out_valid;
  logic [63:0]               out_block;

  logic [31:0] key_mem [mbc_pkg::KEY_COUNT];

  logic                       accept;
  logic                       start;
  logic                       wr_en;
  logic                       rd_en;
  logic [mbc_pkg::KEY_AW-1:0] rnd_next;
  logic [mbc_pkg::KEY_AW-1:0] rd_idx;
  logic [31:0]                f_out;
  logic                       last_rnd;
  logic                       finish;

  // Request handshake and decode.
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign start     = accept && ((req.func == mbc_pkg::FUNC_ENC) ||
                                (req.func == mbc_pkg::FUNC_DEC));
  assign wr_en     = accept && (req.func == mbc_pkg::FUNC_LOAD);

  // Key fetch address: first key on start, next round's key while running.
  assign rnd_next = rnd + 1'b1;
  assign last_rnd = (rnd == mbc_pkg::KEY_LAST);
  always_comb begin
    if (state == ST_IDLE) begin
      rd_idx = (req.func == mbc_pkg::FUNC_DEC) ? mbc_pkg::KEY_LAST : '0;
    end else begin
      rd_idx = dir ? ~rnd_next : rnd_next;
    end
  end
  assign rd_en = start || ((state == ST_RUN) && !last_rnd);

  // Round datapath and completion condition.
  assign f_out  = mbc_pkg::round_f(lo, key_q);
  assign finish = (state == ST_RUN) && last_rnd && (!out_valid || rsp.ready);

  // Key store: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[req.key_index] <= req.key_word;
    end
    if (rd_en) begin
      key_q <= key_mem[rd_idx];
    end
  end

  // Sequencer, round registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      dir       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            rnd   <= '0;
            dir   <= (req.func == mbc_pkg::FUNC_DEC);
            hi    <= req.data_block[63:32];
            lo    <= req.data_block[31:0];
          end
        end
        ST_RUN: begin
          if (!last_rnd) begin
            hi  <= lo;
            lo  <= hi ^ f_out;
            rnd <= rnd_next;
          end else if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // The final round skips the swap and lands straight in the output register.
      if (finish) begin
        out_valid <= 1'b1;
        out_block <= {hi ^ f_out, lo};
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_block = out_block;

  // A started item begins at round zero on the next cycle.
  a_start_round0: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ST_RUN) && (rnd == '0))
    else $error("cipher item did not start at round zero");

  // Rounds advance by one per cycle until the last.
  a_round_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && !last_rnd |=> (state == ST_RUN) && (rnd == $past(rnd_next)))
    else $error("round counter did not advance");

  // Finishing the last round leaves a result pending and the block idle.
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && (state == ST_IDLE))
    else $error("last round did not deliver a result");

endmodule
